FILE: sv/mstb_pkg.sv
`default_nettype none

package mstb_pkg;

   localparam int SLOTS       = 8;
   localparam int MAX_RESULTS = 8;
   localparam int TICK_BITS   = 32;
   localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   localparam logic [15:0] TICK_SCALE_RESET = 16'd1000;
   localparam logic [15:0] MAX_PERIOD_RESET = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_SCALE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PERIOD = 1'b1;

   typedef enum logic [2:0] {
      CMD_ALLOC = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_FREE  = 3'd3,
      CMD_TICK  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD      = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EV_FIRE   = 2'd0,
      EV_FINAL  = 2'd1,
      EV_SINGLE = 2'd2
   } ev_kind_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_FINISH = 2'd2
   } state_type;

   // static part of a slot, written by allocate only
   typedef struct packed {
      logic [7:0]  handle;
      logic [15:0] period;
      logic        reload;
      logic [31:0] word;
      logic [15:0] tag;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // event handed from the sequencer to the response stage
   typedef struct packed {
      ev_kind_type kind;
      status_type  status;
      logic [7:0]  handle;
      logic [31:0] word;
      logic [15:0] tag;
   } ev_type;

endpackage

`default_nettype wire

FILE: sv/multi_slot_timer_bank_core.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// req_*     in         req_valid / req_ready  cmd, handle, period, reload, user_word,
//                                             user_tag, now
// rsp_*     out        rsp_valid / rsp_ready  status, fired, fired_handle, fired_word,
//                                             fired_tag, last
// csr_*     in         csr_we                 csr_index, csr_wdata (write only)
//
// A request is accepted in S_IDLE; S_SCAN then reads one slot of the slot memory per
// cycle unless a held expiry stalls it, and S_FINISH closes the request.
// From the second expiry of a tick on, and in the closing cycle, a full output
// register with rsp_ready low holds the scan for as long as the stall lasts.
// Reset clears slot used/running bits and the control state; slot memories are
// not cleared and need no clearing pass.
// A new request is taken while the previous response still waits in the output register.

module multi_slot_timer_bank_core
   import mstb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [2:0]            req_cmd,
   input  wire logic [7:0]            req_handle,
   input  wire logic [15:0]           req_period,
   input  wire logic                  req_reload,
   input  wire logic [31:0]           req_user_word,
   input  wire logic [15:0]           req_user_tag,
   input  wire logic [31:0]           req_now,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_fired,
   output logic [7:0]                 rsp_fired_handle,
   output logic [31:0]                rsp_fired_word,
   output logic [15:0]                rsp_fired_tag,
   output logic                       rsp_last,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [2:0]           cmd_ff;
   logic [7:0]           handle_ff;
   logic [15:0]          period_ff;
   logic                 reload_ff;
   logic [31:0]          word_ff;
   logic [15:0]          tag_ff;
   logic [TICK_BITS-1:0] now_ff;

   logic [15:0] tick_scale_ff;
   logic [15:0] max_period_ff;

   logic [SLOTS-1:0] used_ff, used_in;
   logic [SLOTS-1:0] running_ff, running_in;

   logic [IDX_W-1:0] iss_idx_ff, iss_idx_in;
   logic             scan_iss_ff, scan_iss_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in;
   logic [15:0]      found_period_ff, found_period_in;
   logic [CNT_W-1:0] n_ff, n_in;

   logic                 wb_vld_ff, wb_vld_in;
   logic [IDX_W-1:0]     wb_idx_ff, wb_idx_in;
   logic [TICK_BITS-1:0] prod_ff, prod_in;

   logic                 rd_en;
   rec_type              rec_rd;
   logic [TICK_BITS-1:0] tgt_rd;
   logic                 wa_we;
   logic [IDX_W-1:0]     wa_idx;
   rec_type              wa_data;
   logic [TICK_BITS-1:0] wb_data;

   logic [15:0]          mul_period;
   logic [TICK_BITS-1:0] product;
   logic                 hit;
   logic                 fire;
   logic                 any_free;
   logic [IDX_W-1:0]     free_idx;
   logic [IDX_W-1:0]     alloc_idx;

   logic   ev_valid;
   ev_type ev;
   logic   ev_ready;

   // ---------------------------------------------------------------- slot memories
   mstb_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_rec_ram (
      .clock (clock),
      .we    (wa_we),
      .waddr (wa_idx),
      .wdata (wa_data),
      .re    (rd_en),
      .raddr (iss_idx_ff),
      .rdata (rec_rd)
   );

   mstb_ram #(.WIDTH(TICK_BITS), .DEPTH(SLOTS)) u_tgt_ram (
      .clock (clock),
      .we    (wb_vld_ff),
      .waddr (wb_idx_ff),
      .wdata (wb_data),
      .re    (rd_en),
      .raddr (iss_idx_ff),
      .rdata (tgt_rd)
   );

   assign wa_data = '{handle: handle_ff, period: period_ff, reload: reload_ff,
                      word: word_ff, tag: tag_ff};
   assign wb_data = now_ff + prod_ff;

   // one shared 16x16 multiplier: slot period during a tick, found period on start
   assign mul_period = (state_ff == S_SCAN) ? rec_rd.period : found_period_ff;
   assign product    = TICK_BITS'({16'd0, mul_period} * {16'd0, tick_scale_ff});

   assign hit  = chk_vld_ff && used_ff[chk_idx_ff] && (rec_rd.handle == handle_ff);
   assign fire = chk_vld_ff && (cmd_ff == CMD_TICK) && (n_ff < CNT_W'(MAX_RESULTS))
                 && used_ff[chk_idx_ff] && running_ff[chk_idx_ff] && (now_ff >= tgt_rd);

   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (!used_ff[k]) begin
            any_free = 1'b1;
            free_idx = IDX_W'(k);
         end
      end
   end

   assign alloc_idx = found_ff ? found_idx_ff : free_idx;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in        = state_ff;
      used_in         = used_ff;
      running_in      = running_ff;
      iss_idx_in      = iss_idx_ff;
      scan_iss_in     = scan_iss_ff;
      chk_vld_in      = chk_vld_ff;
      chk_idx_in      = chk_idx_ff;
      found_in        = found_ff;
      found_idx_in    = found_idx_ff;
      found_period_in = found_period_ff;
      n_in            = n_ff;
      wb_vld_in       = 1'b0;
      wb_idx_in       = wb_idx_ff;
      prod_in         = prod_ff;
      rd_en           = 1'b0;
      wa_we           = 1'b0;
      wa_idx          = alloc_idx;
      ev_valid        = 1'b0;
      ev              = '0;
      req_ready       = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in    = S_SCAN;
               iss_idx_in  = '0;
               scan_iss_in = 1'b1;
               chk_vld_in  = 1'b0;
               found_in    = 1'b0;
               n_in        = '0;
            end
         end

         S_SCAN: begin
            ev_valid  = fire;
            ev.kind   = EV_FIRE;
            ev.status = ST_OK;
            ev.handle = rec_rd.handle;
            ev.word   = rec_rd.word;
            ev.tag    = rec_rd.tag;
            // hold the whole read pipe while an expiry cannot be handed on
            if (!(fire && !ev_ready)) begin
               rd_en      = scan_iss_ff;
               chk_vld_in = scan_iss_ff;
               chk_idx_in = iss_idx_ff;
               if (scan_iss_ff) begin
                  iss_idx_in = iss_idx_ff + IDX_W'(1);
                  if (iss_idx_ff == LAST_IDX) begin
                     scan_iss_in = 1'b0;
                  end
               end
               if (hit && !found_ff) begin
                  found_in        = 1'b1;
                  found_idx_in    = chk_idx_ff;
                  found_period_in = rec_rd.period;
               end
               if (fire) begin
                  n_in = n_ff + CNT_W'(1);
                  if (rec_rd.reload) begin
                     wb_vld_in = 1'b1;
                     wb_idx_in = chk_idx_ff;
                     prod_in   = product;
                  end else begin
                     running_in[chk_idx_ff] = 1'b0;
                  end
               end
               if (chk_vld_ff && (chk_idx_ff == LAST_IDX)) begin
                  state_in = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            ev_valid  = 1'b1;
            ev.kind   = EV_SINGLE;
            ev.status = ST_OK;
            unique case (cmd_ff)
               CMD_ALLOC: begin
                  if ((period_ff == 16'd0) || (period_ff > max_period_ff)) begin
                     ev.status = ST_BAD;
                  end else if (!found_ff && !any_free) begin
                     ev.status = ST_FULL;
                  end else if (ev_ready) begin
                     wa_we                 = 1'b1;
                     used_in[alloc_idx]    = 1'b1;
                     running_in[alloc_idx] = 1'b0;
                  end
               end
               CMD_START, CMD_STOP, CMD_FREE: begin
                  if (!found_ff) begin
                     ev.status = ST_NOTFOUND;
                  end else if (ev_ready) begin
                     if (cmd_ff == CMD_START) begin
                        // target is registered through prod_ff and wb_vld_ff before it is written to the memory
                        wb_vld_in                = 1'b1;
                        wb_idx_in                = found_idx_ff;
                        prod_in                  = product;
                        running_in[found_idx_ff] = 1'b1;
                     end else begin
                        running_in[found_idx_ff] = 1'b0;
                        if (cmd_ff == CMD_FREE) begin
                           used_in[found_idx_ff] = 1'b0;
                        end
                     end
                  end
               end
               CMD_TICK: begin
                  ev.kind = EV_FINAL;
               end
               default: begin
                  ev.status = ST_BAD;
               end
            endcase
            if (ev_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         running_ff    <= '0;
         iss_idx_ff    <= '0;
         scan_iss_ff   <= 1'b0;
         chk_vld_ff    <= 1'b0;
         chk_idx_ff    <= '0;
         found_ff      <= 1'b0;
         n_ff          <= '0;
         wb_vld_ff     <= 1'b0;
         tick_scale_ff <= TICK_SCALE_RESET;
         max_period_ff <= MAX_PERIOD_RESET;
      end else begin
         state_ff    <= state_in;
         used_ff     <= used_in;
         running_ff  <= running_in;
         iss_idx_ff  <= iss_idx_in;
         scan_iss_ff <= scan_iss_in;
         chk_vld_ff  <= chk_vld_in;
         chk_idx_ff  <= chk_idx_in;
         found_ff    <= found_in;
         n_ff        <= n_in;
         wb_vld_ff   <= wb_vld_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TICK_SCALE: tick_scale_ff <= csr_wdata;
               CSR_MAX_PERIOD: max_period_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      found_idx_ff    <= found_idx_in;
      found_period_ff <= found_period_in;
      wb_idx_ff       <= wb_idx_in;
      prod_ff         <= prod_in;
      if (req_valid && req_ready) begin
         cmd_ff    <= req_cmd;
         handle_ff <= req_handle;
         period_ff <= req_period;
         reload_ff <= req_reload;
         word_ff   <= req_user_word;
         tag_ff    <= req_user_tag;
         now_ff    <= req_now;
      end
   end

   // ---------------------------------------------------------------- response stage
   mstb_rsp_stage u_rsp (
      .clock            (clock),
      .reset            (reset),
      .ev_valid         (ev_valid),
      .ev               (ev),
      .ev_ready         (ev_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_fired        (rsp_fired),
      .rsp_fired_handle (rsp_fired_handle),
      .rsp_fired_word   (rsp_fired_word),
      .rsp_fired_tag    (rsp_fired_tag),
      .rsp_last         (rsp_last)
   );

`ifndef ASSERT_OFF
   a_no_rw_same_slot: assert property (@(posedge clock) disable iff (reset)
      (wb_vld_ff && rd_en) |-> (wb_idx_ff != iss_idx_ff))
      else $error("target write and read hit the same slot");

   a_wb_done_by_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !wb_vld_ff)
      else $error("target write still pending after new request");

   a_chk_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == S_SCAN))
      else $error("check stage live outside scan");

   a_expiry_limit: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(MAX_RESULTS))
      else $error("expiry count beyond limit");
`endif

endmodule

`default_nettype wire

FILE: sv/mstb_ram.sv
`default_nettype none

module mstb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                      wdata,
   input  wire logic                                  re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/mstb_rsp_stage.sv
`default_nettype none

module mstb_rsp_stage
   import mstb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        ev_valid,
   input  wire ev_type      ev,
   output logic             ev_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_fired,
   output logic [7:0]       rsp_fired_handle,
   output logic [31:0]      rsp_fired_word,
   output logic [15:0]      rsp_fired_tag,
   output logic             rsp_last
);

   // an expiry is parked until the next one (or the end of the tick) tells us
   // whether it is the final result of the request
   logic        pend_vld_ff, pend_vld_in;
   logic [7:0]  pend_handle_ff, pend_handle_in;
   logic [31:0] pend_word_ff, pend_word_in;
   logic [15:0] pend_tag_ff, pend_tag_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_fired_ff, rsp_fired_in;
   logic [7:0]  rsp_handle_ff, rsp_handle_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [15:0] rsp_tag_ff, rsp_tag_in;
   logic        rsp_last_ff, rsp_last_in;

   logic can_push;
   logic park_only;
   logic push;

   assign can_push  = !rsp_valid_ff || rsp_ready;
   assign park_only = (ev.kind == EV_FIRE) && !pend_vld_ff;
   assign ev_ready  = park_only || can_push;
   assign push      = ev_valid && ev_ready && !park_only;

   always_comb begin
      pend_vld_in    = pend_vld_ff;
      pend_handle_in = pend_handle_ff;
      pend_word_in   = pend_word_ff;
      pend_tag_in    = pend_tag_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_fired_in   = rsp_fired_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (push) begin
         rsp_valid_in = 1'b1;
         unique case (ev.kind)
            EV_FIRE, EV_FINAL: begin
               rsp_status_in = ST_OK;
               rsp_fired_in  = pend_vld_ff;
               rsp_handle_in = pend_vld_ff ? pend_handle_ff : 8'd0;
               rsp_word_in   = pend_vld_ff ? pend_word_ff : 32'd0;
               rsp_tag_in    = pend_vld_ff ? pend_tag_ff : 16'd0;
               rsp_last_in   = (ev.kind == EV_FINAL);
            end
            default: begin
               rsp_status_in = ev.status;
               rsp_fired_in  = 1'b0;
               rsp_handle_in = 8'd0;
               rsp_word_in   = 32'd0;
               rsp_tag_in    = 16'd0;
               rsp_last_in   = 1'b1;
            end
         endcase
      end

      if (ev_valid && ev_ready) begin
         if (ev.kind == EV_FIRE) begin
            pend_vld_in    = 1'b1;
            pend_handle_in = ev.handle;
            pend_word_in   = ev.word;
            pend_tag_in    = ev.tag;
         end else if (ev.kind == EV_FINAL) begin
            pend_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_handle_ff <= pend_handle_in;
      pend_word_ff   <= pend_word_in;
      pend_tag_ff    <= pend_tag_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_word_ff    <= rsp_word_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_fired_handle = rsp_handle_ff;
   assign rsp_fired_word   = rsp_word_ff;
   assign rsp_fired_tag    = rsp_tag_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef ASSERT_OFF
   a_final_clears_pend: assert property (@(posedge clock) disable iff (reset)
      (ev_valid && ev_ready && ev.kind == EV_FINAL) |=> !pend_vld_ff)
      else $error("parked expiry survived end of tick");

   a_fire_push_not_last: assert property (@(posedge clock) disable iff (reset)
      (ev_valid && ev_ready && ev.kind == EV_FIRE && pend_vld_ff)
      |=> (rsp_valid_ff && rsp_fired_ff && !rsp_last_ff))
      else $error("earlier expiry not pushed as non-final");

   a_final_push_last: assert property (@(posedge clock) disable iff (reset)
      (ev_valid && ev_ready && ev.kind != EV_FIRE) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("closing response missing last");
`endif

endmodule

`default_nettype wire
